FILE: design/pyrochlore_metropolis_flip_macros.svh
// Assertion macros for the Metropolis spin-flip block.
// Standalone header; used by the top level only.
`ifndef PYROCHLORE_METROPOLIS_FLIP_MACROS_SVH
`define PYROCHLORE_METROPOLIS_FLIP_MACROS_SVH

// same-cycle implication
`define PMF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmf assertion failed");

// next-cycle implication
`define PMF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmf assertion failed");

`endif

FILE: design/pmf_pkg.sv
// Shared types and constants for the Metropolis spin-flip block.
// No dependencies.
package pmf_pkg;

   localparam int NUM_SITES    = 1024;
   localparam int ADDR_W       = $clog2(NUM_SITES);
   localparam int SITE_W       = 10;
   localparam int NBR_COUNT    = 6;
   localparam int THRESH_DEPTH = 56;
   localparam int THRESH_W     = 33;
   localparam int RAND_W       = 32;
   localparam int TIDX_W       = 6;
   localparam int ROW_STEP     = 14;
   localparam int SPIN_STEP    = 7;

   typedef enum logic [1:0] {
      CMD_LOAD_SITE   = 2'd0,
      CMD_LOAD_THRESH = 2'd1,
      CMD_FLIP        = 2'd2,
      CMD_READ_SITE   = 2'd3
   } cmd_type;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_READ   = 6'b000010,
      S_NBR    = 6'b000100,
      S_GATHER = 6'b001000,
      S_DECIDE = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   typedef logic [NBR_COUNT-1:0][SITE_W-1:0] nbr_set_type;

   localparam logic [15:0][1:0] AXIS_MAP = {
      2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd3, 2'd0, 2'd2,
      2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0
   };

endpackage

FILE: design/pmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/pyrochlore_metropolis_flip.sv
// Top level of the Metropolis single-spin update engine.
// Depends on pmf_pkg, pmf_ram and pyrochlore_metropolis_flip_macros.svh.
//
//   channel | direction | handshake              | payload
//   req_    | in        | req_valid / req_stall  | cmd, site, spin, six nbrs, thresh, random
//   rsp_    | out       | rsp_valid / rsp_stall  | accepted, spin_now, neighbour_sum, axis_kind
//
// One transaction at a time. In a flip attempt the six neighbour spins are fetched one
// per cycle through the single read port of the spin RAM, then the threshold RAM is read.
// Reset is synchronous; it clears control state only, the RAMs need no clearing pass.
// A finished result waits in the output register while the next transaction is taken.
`include "pyrochlore_metropolis_flip_macros.svh"

module pyrochlore_metropolis_flip (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_cmd,
   input  logic [9:0]        req_site,
   input  logic              req_spin_in,
   input  logic [9:0]        req_nbr_a,
   input  logic [9:0]        req_nbr_b,
   input  logic [9:0]        req_nbr_c,
   input  logic [9:0]        req_nbr_d,
   input  logic [9:0]        req_nbr_e,
   input  logic [9:0]        req_nbr_f,
   input  logic [5:0]        req_thresh_index,
   input  logic [32:0]       req_thresh_value,
   input  logic [31:0]       req_random_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_accepted,
   output logic              rsp_spin_now,
   output logic signed [3:0] rsp_neighbour_sum,
   output logic [1:0]        rsp_axis_kind
);

   pmf_pkg::state_type    state_ff, state_in;
   pmf_pkg::cmd_type      req_cmd_e;
   logic [2:0]            cnt_ff, cnt_in;
   logic [2:0]            ones_ff, ones_in;
   logic                  sp_ff, sp_in;
   logic [1:0]            axis_ff, axis_in;
   logic [pmf_pkg::ADDR_W-1:0] site_ff, site_in;
   logic [pmf_pkg::RAND_W-1:0] rand_ff, rand_in;
   pmf_pkg::nbr_set_type  nbr_ff, nbr_in;

   logic                  res_acc_ff, res_acc_in;
   logic                  res_spin_ff, res_spin_in;
   logic [3:0]            res_sum_ff, res_sum_in;
   logic [1:0]            res_axis_ff, res_axis_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_acc_ff, rsp_spin_ff;
   logic [3:0]            rsp_sum_ff;
   logic [1:0]            rsp_axis_ff;

   logic                  req_take;
   logic                  out_load;
   logic                  flip_ok;
   logic [pmf_pkg::TIDX_W-1:0] tidx;

   logic                  spin_we, spin_wd, spin_re, spin_rd;
   logic [pmf_pkg::ADDR_W-1:0] spin_wa, spin_ra;
   logic                  nbr_we, nbr_re;
   pmf_pkg::nbr_set_type  nbr_wd, nbr_rd;
   logic                  th_we, th_re;
   logic [pmf_pkg::THRESH_W-1:0] th_rd;

   assign req_cmd_e = pmf_pkg::cmd_type'(req_cmd);
   assign req_stall = (state_ff != pmf_pkg::S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_load  = (state_ff == pmf_pkg::S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign flip_ok   = ({1'b0, rand_ff} < th_rd);

   assign tidx = pmf_pkg::TIDX_W'(axis_ff) * pmf_pkg::TIDX_W'(pmf_pkg::ROW_STEP)
               + (sp_ff ? pmf_pkg::TIDX_W'(pmf_pkg::SPIN_STEP) : '0)
               + pmf_pkg::TIDX_W'(ones_in);

   // RAM port control
   always_comb begin
      spin_we = 1'b0;
      spin_wa = pmf_pkg::ADDR_W'(req_site);
      spin_wd = req_spin_in;
      spin_re = 1'b0;
      spin_ra = pmf_pkg::ADDR_W'(req_site);
      nbr_we  = req_take && (req_cmd_e == pmf_pkg::CMD_LOAD_SITE);
      nbr_re  = req_take;
      th_we   = req_take && (req_cmd_e == pmf_pkg::CMD_LOAD_THRESH)
                && (req_thresh_index < pmf_pkg::TIDX_W'(pmf_pkg::THRESH_DEPTH));
      th_re   = 1'b0;
      nbr_wd  = {req_nbr_f, req_nbr_e, req_nbr_d, req_nbr_c, req_nbr_b, req_nbr_a};
      case (state_ff)
         pmf_pkg::S_IDLE: begin
            spin_we = req_take && (req_cmd_e == pmf_pkg::CMD_LOAD_SITE);
            spin_re = req_take;
         end
         pmf_pkg::S_NBR: begin
            spin_re = 1'b1;
            spin_ra = pmf_pkg::ADDR_W'(nbr_rd[0]);
         end
         pmf_pkg::S_GATHER: begin
            spin_re = (cnt_ff < 3'(pmf_pkg::NBR_COUNT));
            spin_ra = pmf_pkg::ADDR_W'(nbr_ff[cnt_ff]);
            th_re   = (cnt_ff == 3'(pmf_pkg::NBR_COUNT));
         end
         pmf_pkg::S_DECIDE: begin
            spin_we = flip_ok;
            spin_wa = site_ff;
            spin_wd = ~sp_ff;
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      ones_in     = ones_ff;
      sp_in       = sp_ff;
      axis_in     = axis_ff;
      site_in     = site_ff;
      rand_in     = rand_ff;
      nbr_in      = nbr_ff;
      res_acc_in  = res_acc_ff;
      res_spin_in = res_spin_ff;
      res_sum_in  = res_sum_ff;
      res_axis_in = res_axis_ff;
      case (state_ff)
         pmf_pkg::S_IDLE: begin
            if (req_take) begin
               site_in     = pmf_pkg::ADDR_W'(req_site);
               rand_in     = req_random_value;
               axis_in     = pmf_pkg::AXIS_MAP[req_site[3:0]];
               res_acc_in  = 1'b0;
               res_sum_in  = '0;
               res_axis_in = pmf_pkg::AXIS_MAP[req_site[3:0]];
               res_spin_in = req_spin_in;
               case (req_cmd_e)
                  pmf_pkg::CMD_LOAD_SITE: begin
                     state_in = pmf_pkg::S_DONE;
                  end
                  pmf_pkg::CMD_LOAD_THRESH: begin
                     res_spin_in = 1'b0;
                     res_axis_in = '0;
                     state_in    = pmf_pkg::S_DONE;
                  end
                  pmf_pkg::CMD_FLIP: begin
                     state_in = pmf_pkg::S_NBR;
                  end
                  default: begin
                     state_in = pmf_pkg::S_READ;
                  end
               endcase
            end
         end
         pmf_pkg::S_READ: begin
            res_spin_in = spin_rd;
            state_in    = pmf_pkg::S_DONE;
         end
         pmf_pkg::S_NBR: begin
            sp_in    = spin_rd;
            nbr_in   = nbr_rd;
            ones_in  = '0;
            cnt_in   = 3'd1;
            state_in = pmf_pkg::S_GATHER;
         end
         pmf_pkg::S_GATHER: begin
            ones_in = ones_ff + 3'(spin_rd);
            cnt_in  = cnt_ff + 3'd1;
            if (cnt_ff == 3'(pmf_pkg::NBR_COUNT)) begin
               state_in = pmf_pkg::S_DECIDE;
            end
         end
         pmf_pkg::S_DECIDE: begin
            res_acc_in  = flip_ok;
            res_spin_in = sp_ff ^ flip_ok;
            res_sum_in  = {ones_ff, 1'b0} - 4'd6;
            res_axis_in = axis_ff;
            state_in    = pmf_pkg::S_DONE;
         end
         pmf_pkg::S_DONE: begin
            if (out_load) begin
               state_in = pmf_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pmf_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pmf_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ones_ff     <= ones_in;
      sp_ff       <= sp_in;
      axis_ff     <= axis_in;
      site_ff     <= site_in;
      rand_ff     <= rand_in;
      nbr_ff      <= nbr_in;
      res_acc_ff  <= res_acc_in;
      res_spin_ff <= res_spin_in;
      res_sum_ff  <= res_sum_in;
      res_axis_ff <= res_axis_in;
      if (out_load) begin
         rsp_acc_ff  <= res_acc_ff;
         rsp_spin_ff <= res_spin_ff;
         rsp_sum_ff  <= res_sum_ff;
         rsp_axis_ff <= res_axis_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_spin_now      = rsp_spin_ff;
   assign rsp_neighbour_sum = signed'(rsp_sum_ff);
   assign rsp_axis_kind     = rsp_axis_ff;

   pmf_ram #(.WIDTH(1), .DEPTH(pmf_pkg::NUM_SITES)) u_spin_ram (
      .clock   (clock),
      .wr_en   (spin_we),
      .wr_addr (spin_wa),
      .wr_data (spin_wd),
      .rd_en   (spin_re),
      .rd_addr (spin_ra),
      .rd_data (spin_rd)
   );

   pmf_ram #(
      .WIDTH (pmf_pkg::NBR_COUNT * pmf_pkg::SITE_W),
      .DEPTH (pmf_pkg::NUM_SITES)
   ) u_nbr_ram (
      .clock   (clock),
      .wr_en   (nbr_we),
      .wr_addr (pmf_pkg::ADDR_W'(req_site)),
      .wr_data (nbr_wd),
      .rd_en   (nbr_re),
      .rd_addr (pmf_pkg::ADDR_W'(req_site)),
      .rd_data (nbr_rd)
   );

   pmf_ram #(.WIDTH(pmf_pkg::THRESH_W), .DEPTH(pmf_pkg::THRESH_DEPTH)) u_thresh_ram (
      .clock   (clock),
      .wr_en   (th_we),
      .wr_addr (req_thresh_index),
      .wr_data (req_thresh_value),
      .rd_en   (th_re),
      .rd_addr (tidx),
      .rd_data (th_rd)
   );

   `PMF_ASSERT_IMP(a_gather_count, clock, reset, state_ff == pmf_pkg::S_GATHER,
                   cnt_ff >= 3'd1 && cnt_ff <= 3'(pmf_pkg::NBR_COUNT))
   `PMF_ASSERT_NXT(a_nbr_to_gather, clock, reset, state_ff == pmf_pkg::S_NBR,
                   state_ff == pmf_pkg::S_GATHER && ones_ff == 3'd0)
   `PMF_ASSERT_IMP(a_accept_even_sum, clock, reset, rsp_valid_ff && rsp_acc_ff,
                   rsp_sum_ff[0] == 1'b0)
   `PMF_ASSERT_NXT(a_rsp_from_done, clock, reset, out_load, rsp_valid_ff)

endmodule
